// File: sv/natl_pkg.sv
package natl_pkg;

  localparam int FRAC_BITS = 15;

  // Configuration register indexes
  localparam logic [1:0] CFG_TARGET_IS_BUS = 2'd0;
  localparam logic [1:0] CFG_MIN_DIST      = 2'd1;
  localparam logic [1:0] CFG_MAX_DIST      = 2'd2;
  localparam logic [1:0] CFG_LOST_TIMEOUT  = 2'd3;

  // Reset values of the configuration registers
  localparam logic [19:0] MAX_DIST_RST     = 20'd100000;
  localparam logic [31:0] LOST_TIMEOUT_RST = 32'd1000000;

  // Item op codes
  localparam logic OP_OBJECT = 1'b0;
  localparam logic OP_EOF    = 1'b1;

  // Result status codes
  typedef logic [2:0] status_t;
  localparam status_t ST_FRAME_BAD   = 3'd0;
  localparam status_t ST_KEEP        = 3'd1;
  localparam status_t ST_KEEP_LOST   = 3'd2;
  localparam status_t ST_SELECT      = 3'd3;
  localparam status_t ST_NONE        = 3'd4;
  localparam status_t ST_UNLOCK_BAD  = 3'd5;
  localparam status_t ST_UNLOCK_LOST = 3'd6;

endpackage

// File: sv/nearest_ahead_target_lock.sv
// Channel | handshake             | fields
// --------+-----------------------+-----------------------------------------------------------
// in      | in_valid / in_stall   | op, ids, class_bus, positions, heading, stamp_us, frame_ok
// out     | out_valid / out_stall | target_valid, target ids, changed, status, distance_mm
// cfg     | cfg_we                | cfg_index, cfg_data (write only)
//
// One word per cycle while in_stall is low. Pipeline: input reg (offsets) -> products -> dot sum,
// range tests, rounding -> accumulators / frame decision -> output reg.
// A result is loaded into the output reg when its end-of-frame word is at the decision stage and that reg is not held.
// rst_n (sync, active low) clears the lock, the frame accumulators and the
// pipeline valids, and loads the configuration reset values.
// in_stall rises only while an end-of-frame word sits at the decision stage
// and the output word is still held by out_stall; the whole pipe then freezes.
module nearest_ahead_target_lock
  import natl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [63:0]        in_id_high,
  input  logic [63:0]        in_id_low,
  input  logic               in_class_bus,
  input  logic signed [31:0] in_obj_x,
  input  logic signed [31:0] in_obj_y,
  input  logic signed [31:0] in_ego_x,
  input  logic signed [31:0] in_ego_y,
  input  logic signed [15:0] in_heading_cos,
  input  logic signed [15:0] in_heading_sin,
  input  logic [47:0]        in_stamp_us,
  input  logic               in_frame_ok,

  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_target_valid,
  output logic [63:0]        out_target_id_high,
  output logic [63:0]        out_target_id_low,
  output logic               out_changed,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_distance_mm
);

  // ---------------- configuration ----------------
  logic        target_is_bus_r;
  logic [19:0] min_dist_r;
  logic [19:0] max_dist_r;
  logic [31:0] lost_timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_is_bus_r <= 1'b1;
      min_dist_r      <= '0;
      max_dist_r      <= MAX_DIST_RST;
      lost_timeout_r  <= LOST_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_IS_BUS: target_is_bus_r <= cfg_data[0];
        CFG_MIN_DIST:      min_dist_r      <= cfg_data[19:0];
        CFG_MAX_DIST:      max_dist_r      <= cfg_data[19:0];
        CFG_LOST_TIMEOUT:  lost_timeout_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  // The whole pipeline holds only when an end-of-frame word must load the
  // output register while that register is still waiting.
  logic s3_v_r, s3_op_r;
  logic out_valid_r;
  logic hold;
  logic res_load;

  assign hold     = out_valid_r & out_stall & s3_v_r & (s3_op_r == OP_EOF);
  assign in_stall = hold;
  assign res_load = s3_v_r & (s3_op_r == OP_EOF) & ~hold;

  // ---------------- stage 1: input register, offsets from ego ----------------
  logic               s1_v_r, s1_op_r, s1_class_r, s1_frame_ok_r;
  logic [63:0]        s1_idh_r, s1_idl_r;
  logic signed [32:0] s1_rx_r, s1_ry_r;
  logic signed [15:0] s1_cos_r, s1_sin_r;
  logic [47:0]        s1_stamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!hold) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      s1_op_r       <= in_op;
      s1_idh_r      <= in_id_high;
      s1_idl_r      <= in_id_low;
      s1_class_r    <= in_class_bus;
      s1_rx_r       <= {in_obj_x[31], in_obj_x} - {in_ego_x[31], in_ego_x};
      s1_ry_r       <= {in_obj_y[31], in_obj_y} - {in_ego_y[31], in_ego_y};
      s1_cos_r      <= in_heading_cos;
      s1_sin_r      <= in_heading_sin;
      s1_stamp_r    <= in_stamp_us;
      s1_frame_ok_r <= in_frame_ok;
    end
  end

  // ---------------- stage 2: the two products (Q.15 mm) ----------------
  logic               s2_v_r, s2_op_r, s2_class_r, s2_frame_ok_r;
  logic [63:0]        s2_idh_r, s2_idl_r;
  logic signed [48:0] s2_px_r, s2_py_r;
  logic [47:0]        s2_stamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (!hold) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      s2_op_r       <= s1_op_r;
      s2_idh_r      <= s1_idh_r;
      s2_idl_r      <= s1_idl_r;
      s2_class_r    <= s1_class_r;
      s2_px_r       <= s1_rx_r * s1_cos_r;
      s2_py_r       <= s1_ry_r * s1_sin_r;
      s2_stamp_r    <= s1_stamp_r;
      s2_frame_ok_r <= s1_frame_ok_r;
    end
  end

  // ---------------- stage 3: projection, qualify, round ----------------
  logic signed [49:0] proj;
  logic signed [49:0] lo_lim, hi_lim;
  logic [49:0]        proj_rnd;
  logic               qual;

  assign proj     = {s2_px_r[48], s2_px_r} + {s2_py_r[48], s2_py_r};
  assign lo_lim   = $signed({15'd0, min_dist_r, 15'd0});
  assign hi_lim   = $signed({15'd0, max_dist_r, 15'd0});
  assign proj_rnd = proj + 50'sd16384;
  // strictly ahead and inside [min, max]; only a bus qualifies, and only when bus is the target
  assign qual     = target_is_bus_r & s2_class_r & (proj > 50'sd0) &
                    (proj >= lo_lim) & (proj <= hi_lim);

  logic        s3_qual_r, s3_frame_ok_r;
  logic [63:0] s3_idh_r, s3_idl_r;
  logic [31:0] s3_dist_r;
  logic [47:0] s3_stamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (!hold) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      s3_op_r       <= s2_op_r;
      s3_idh_r      <= s2_idh_r;
      s3_idl_r      <= s2_idl_r;
      s3_qual_r     <= qual;
      s3_dist_r     <= qual ? proj_rnd[FRAC_BITS +: 32] : 32'd0;
      s3_stamp_r    <= s2_stamp_r;
      s3_frame_ok_r <= s2_frame_ok_r;
    end
  end

  // ---------------- stage 4: accumulators and frame decision ----------------
  logic        lock_held_r, lock_held_nxt;
  logic [63:0] lock_idh_r, lock_idh_nxt, lock_idl_r, lock_idl_nxt;
  logic [47:0] last_seen_r, last_seen_nxt;
  logic        lock_seen_r, lock_seen_nxt;
  logic        lock_ok_r, lock_ok_nxt;
  logic [31:0] lock_dist_r, lock_dist_nxt;
  logic        best_found_r, best_found_nxt;
  logic [63:0] best_idh_r, best_idh_nxt, best_idl_r, best_idl_nxt;
  logic [31:0] best_dist_r, best_dist_nxt;

  logic        res_tv, res_changed;
  logic [63:0] res_idh, res_idl;
  status_t     res_status;
  logic [31:0] res_dist;

  logic        id_match;
  logic        better;
  logic [47:0] elapsed;
  logic        in_time;
  logic        kept;

  assign id_match = (s3_idh_r == lock_idh_r) && (s3_idl_r == lock_idl_r);
  assign better   = s3_qual_r && (!best_found_r || (s3_dist_r < best_dist_r));
  assign elapsed  = s3_stamp_r - last_seen_r;
  // a stamp that went backwards counts as within the timeout
  assign in_time  = (s3_stamp_r < last_seen_r) || (elapsed <= {16'd0, lost_timeout_r});

  always_comb begin
    lock_held_nxt  = lock_held_r;
    lock_idh_nxt   = lock_idh_r;
    lock_idl_nxt   = lock_idl_r;
    last_seen_nxt  = last_seen_r;
    lock_seen_nxt  = lock_seen_r;
    lock_ok_nxt    = lock_ok_r;
    lock_dist_nxt  = lock_dist_r;
    best_found_nxt = best_found_r;
    best_idh_nxt   = best_idh_r;
    best_idl_nxt   = best_idl_r;
    best_dist_nxt  = best_dist_r;
    res_tv         = 1'b0;
    res_changed    = 1'b0;
    res_idh        = '0;
    res_idl        = '0;
    res_status     = ST_FRAME_BAD;
    res_dist       = '0;
    kept           = 1'b0;

    if (s3_v_r && !hold) begin
      if (s3_op_r == OP_OBJECT) begin
        // only the first occurrence of the locked id counts
        if (lock_held_r && !lock_seen_r && id_match) begin
          lock_seen_nxt = 1'b1;
          lock_ok_nxt   = s3_qual_r;
          lock_dist_nxt = s3_dist_r;
        end
        // strict less-than: earliest candidate wins a tie
        if (better) begin
          best_found_nxt = 1'b1;
          best_idh_nxt   = s3_idh_r;
          best_idl_nxt   = s3_idl_r;
          best_dist_nxt  = s3_dist_r;
        end
      end else begin
        if (s3_frame_ok_r) begin
          res_status = ST_NONE;
          if (lock_held_r) begin
            if (lock_seen_r) begin
              if (lock_ok_r) begin
                last_seen_nxt = s3_stamp_r;
                res_tv     = 1'b1;
                res_idh    = lock_idh_r;
                res_idl    = lock_idl_r;
                res_status = ST_KEEP;
                res_dist   = lock_dist_r;
                kept       = 1'b1;
              end else begin
                res_changed   = 1'b1;
                res_status    = ST_UNLOCK_BAD;
                lock_held_nxt = 1'b0;
              end
            end else if (in_time) begin
              res_tv     = 1'b1;
              res_idh    = lock_idh_r;
              res_idl    = lock_idl_r;
              res_status = ST_KEEP_LOST;
              kept       = 1'b1;
            end else begin
              res_changed   = 1'b1;
              res_status    = ST_UNLOCK_LOST;
              lock_held_nxt = 1'b0;
            end
          end
          if (!kept && best_found_r) begin
            lock_held_nxt = 1'b1;
            lock_idh_nxt  = best_idh_r;
            lock_idl_nxt  = best_idl_r;
            last_seen_nxt = s3_stamp_r;
            res_tv        = 1'b1;
            res_idh       = best_idh_r;
            res_idl       = best_idl_r;
            res_changed   = 1'b1;
            res_status    = ST_SELECT;
            res_dist      = best_dist_r;
          end
        end
        // every end of frame starts a fresh frame
        lock_seen_nxt  = 1'b0;
        lock_ok_nxt    = 1'b0;
        lock_dist_nxt  = '0;
        best_found_nxt = 1'b0;
        best_idh_nxt   = '0;
        best_idl_nxt   = '0;
        best_dist_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_held_r  <= 1'b0;
      lock_idh_r   <= '0;
      lock_idl_r   <= '0;
      last_seen_r  <= '0;
      lock_seen_r  <= 1'b0;
      lock_ok_r    <= 1'b0;
      lock_dist_r  <= '0;
      best_found_r <= 1'b0;
      best_idh_r   <= '0;
      best_idl_r   <= '0;
      best_dist_r  <= '0;
    end else begin
      lock_held_r  <= lock_held_nxt;
      lock_idh_r   <= lock_idh_nxt;
      lock_idl_r   <= lock_idl_nxt;
      last_seen_r  <= last_seen_nxt;
      lock_seen_r  <= lock_seen_nxt;
      lock_ok_r    <= lock_ok_nxt;
      lock_dist_r  <= lock_dist_nxt;
      best_found_r <= best_found_nxt;
      best_idh_r   <= best_idh_nxt;
      best_idl_r   <= best_idl_nxt;
      best_dist_r  <= best_dist_nxt;
    end
  end

  // ---------------- output register ----------------
  logic        out_valid_nxt;
  logic        out_tv_r, out_changed_r;
  logic [63:0] out_idh_r, out_idl_r;
  status_t     out_status_r;
  logic [31:0] out_dist_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_tv_r      <= res_tv;
      out_idh_r     <= res_idh;
      out_idl_r     <= res_idl;
      out_changed_r <= res_changed;
      out_status_r  <= res_status;
      out_dist_r    <= res_dist;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_target_valid   = out_tv_r;
  assign out_target_id_high = out_idh_r;
  assign out_target_id_low  = out_idl_r;
  assign out_changed        = out_changed_r;
  assign out_status         = out_status_r;
  assign out_distance_mm    = $signed(out_dist_r);

  // ---------------- assertions ----------------
  // input side waits only behind a held output word
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held output word");

  // a reported target goes with keep, keep-lost or select, and nothing else
  a_tv_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_target_valid == ((out_status == ST_KEEP) ||
                   (out_status == ST_KEEP_LOST) || (out_status == ST_SELECT))))
    else $error("target_valid disagrees with status");

  // changed marks exactly select and the two unlock outcomes
  a_changed_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_changed == ((out_status == ST_SELECT) ||
                   (out_status == ST_UNLOCK_BAD) || (out_status == ST_UNLOCK_LOST))))
    else $error("changed disagrees with status");

  // a select always leaves a lock held
  a_select_from_best: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && (res_status == ST_SELECT)) |=> lock_held_r)
    else $error("select without a held lock");

endmodule
